// ===== rtl/core/sbfr_pkg.sv =====
// shared types and constants of the seven byte frame receiver
package sbfr_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned PosW       = 3;
  localparam int unsigned KindW      = 2;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CountW     = 3;
  localparam int unsigned NumLocal   = 4;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // byte positions inside a frame
  localparam logic [PosW-1:0] POS_HUNT  = 3'd0;
  localparam logic [PosW-1:0] POS_CHECK = 3'd6;

  // result kinds
  localparam logic [KindW-1:0] KIND_MSG  = 2'd0;
  localparam logic [KindW-1:0] KIND_RESP = 2'd1;
  localparam logic [KindW-1:0] KIND_CLR  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CODE_STD  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CODE_ACK  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CODE_RESP = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ADDR_A    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ADDR_B    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ADDR_C    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_ADDR_D    = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_COUNT     = 3'd7;

  typedef enum logic [1:0] {
    ACT_PASS = 2'd0,
    ACT_ACK  = 2'd1,
    ACT_CLR  = 2'd2
  } act_e;

  typedef struct packed {
    logic [ByteW-1:0]               code_std;
    logic [ByteW-1:0]               code_ack;
    logic [ByteW-1:0]               code_resp;
    logic [NumLocal-1:0][ByteW-1:0] addr;
    logic [CountW-1:0]              count;
  } cfg_t;

  typedef struct packed {
    act_e             act;
    logic [ByteW-1:0] start;
    logic [ByteW-1:0] code_std;
    logic [ByteW-1:0] code_resp;
    logic [ByteW-1:0] src;
    logic [ByteW-1:0] dst;
    logic [ByteW-1:0] cmd;
    logic [ByteW-1:0] data_first;
    logic [ByteW-1:0] data_second;
  } job_t;

endpackage

// ===== rtl/core/sbfr_if.sv =====
// valid/ready channel interfaces for received bytes and results
interface sbfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sbfr_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] start_code;
  logic [7:0] source_addr;
  logic [7:0] dest_addr;
  logic [7:0] command;
  logic [7:0] data_first;
  logic [7:0] data_second;
  logic       last;

  modport source (
    output valid, output kind, output start_code, output source_addr,
    output dest_addr, output command, output data_first, output data_second,
    output last, input ready
  );
  modport sink (
    input valid, input kind, input start_code, input source_addr,
    input dest_addr, input command, input data_first, input data_second,
    input last, output ready
  );
endinterface

// ===== rtl/core/seven_byte_frame_receiver_ack_handler_unit.sv =====
// top level of the seven byte frame receiver with ack handling
// results of a frame pass through the job queue and then the result register after its checksum byte is accepted
// throughput: one byte per cycle unless the queue is full at the checksum byte; an ack frame gives two results
// a two-entry job queue lets the byte side keep running while results stall
// reset: frame assembly returns to hunting, queue and result register empty
// reset: configuration registers return to their default codes and addresses
module seven_byte_frame_receiver_ack_handler_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sbfr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sbfr_pkg::ByteW-1:0]     cfg_data_i,
  sbfr_byte_if.sink                      rx_i,
  sbfr_result_if.source                  res_o
);
  import sbfr_pkg::*;

  cfg_t cfg_q;
  logic push, pop, full, empty;
  job_t job, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_std  <= 8'd1;
      cfg_q.code_ack  <= 8'd2;
      cfg_q.code_resp <= 8'd3;
      cfg_q.addr      <= '0;
      cfg_q.count     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CODE_STD:  cfg_q.code_std  <= cfg_data_i;
        CFG_CODE_ACK:  cfg_q.code_ack  <= cfg_data_i;
        CFG_CODE_RESP: cfg_q.code_resp <= cfg_data_i;
        CFG_ADDR_A:    cfg_q.addr[0]   <= cfg_data_i;
        CFG_ADDR_B:    cfg_q.addr[1]   <= cfg_data_i;
        CFG_ADDR_C:    cfg_q.addr[2]   <= cfg_data_i;
        CFG_ADDR_D:    cfg_q.addr[3]   <= cfg_data_i;
        CFG_COUNT:     cfg_q.count     <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  sbfr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .rx_i     (rx_i),
    .q_full_i (full),
    .push_o   (push),
    .job_o    (job)
  );

  sbfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  sbfr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

// ===== rtl/core/sbfr_front.sv =====
// frame assembler: hunts start codes, collects bytes, checks and classifies frames
module sbfr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sbfr_pkg::cfg_t cfg_i,
  sbfr_byte_if.sink     rx_i,
  input  logic          q_full_i,
  output logic          push_o,
  output sbfr_pkg::job_t job_o
);
  import sbfr_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic [ByteW-1:0] start_q, src_q, dst_q, cmd_q, d1_q, d2_q;
  logic             accept;
  logic             is_code;
  logic             is_local;
  logic             is_std;
  logic [CountW-1:0] n_active;
  act_e             act;

  assign rx_i.ready = (pos_q != POS_CHECK) || !q_full_i;
  assign accept     = rx_i.valid && rx_i.ready;

  assign is_code = (rx_i.rx_byte == cfg_i.code_std) ||
                   (rx_i.rx_byte == cfg_i.code_ack) ||
                   (rx_i.rx_byte == cfg_i.code_resp);

  assign n_active = (cfg_i.count > CountW'(NumLocal)) ? CountW'(NumLocal) : cfg_i.count;

  always_comb begin
    is_local = 1'b0;
    for (int i = 0; i < NumLocal; i++) begin
      if ((CountW'(i) < n_active) && (cfg_i.addr[i] == dst_q)) begin
        is_local = 1'b1;
      end
    end
  end

  assign is_std = (start_q == cfg_i.code_std);

  always_comb begin
    if (!is_std && is_local && (start_q == cfg_i.code_ack)) begin
      act = ACT_ACK;
    end else if (!is_std && is_local && (start_q == cfg_i.code_resp)) begin
      act = ACT_CLR;
    end else begin
      act = ACT_PASS;
    end
  end

  assign push_o = accept && (pos_q == POS_CHECK) && (rx_i.rx_byte == xor_q);

  assign job_o.act         = act;
  assign job_o.start       = start_q;
  assign job_o.code_std    = cfg_i.code_std;
  assign job_o.code_resp   = cfg_i.code_resp;
  assign job_o.src         = src_q;
  assign job_o.dst         = dst_q;
  assign job_o.cmd         = cmd_q;
  assign job_o.data_first  = d1_q;
  assign job_o.data_second = d2_q;

  always_comb begin
    pos_d = pos_q;
    xor_d = xor_q;
    if (accept) begin
      if (pos_q == POS_HUNT) begin
        if (is_code) begin
          pos_d = pos_q + PosW'(1);
          xor_d = rx_i.rx_byte;
        end
      end else if (pos_q == POS_CHECK) begin
        pos_d = POS_HUNT;
        xor_d = '0;
      end else begin
        pos_d = pos_q + PosW'(1);
        xor_d = xor_q ^ rx_i.rx_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_HUNT;
      xor_q <= '0;
    end else begin
      pos_q <= pos_d;
      xor_q <= xor_d;
    end
  end

  // frame byte store
  always_ff @(posedge clk_i) begin
    if (accept) begin
      unique case (pos_q)
        3'd0:    if (is_code) start_q <= rx_i.rx_byte;
        3'd1:    src_q <= rx_i.rx_byte;
        3'd2:    dst_q <= rx_i.rx_byte;
        3'd3:    cmd_q <= rx_i.rx_byte;
        3'd4:    d1_q  <= rx_i.rx_byte;
        3'd5:    d2_q  <= rx_i.rx_byte;
        default: ;
      endcase
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_CHECK)
    else $error("byte position out of range");

  a_push_at_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (pos_q == POS_HUNT))
    else $error("frame pushed but assembler not back to hunting");

endmodule

// ===== rtl/core/sbfr_queue.sv =====
// short job queue between frame assembler and result emitter
module sbfr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sbfr_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output sbfr_pkg::job_t head_o
);
  import sbfr_pkg::*;

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

endmodule

// ===== rtl/core/sbfr_back.sv =====
// result emitter: expands queued jobs into one or two registered results
module sbfr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  sbfr_pkg::job_t head_i,
  output logic           pop_o,
  sbfr_result_if.source  res_o
);
  import sbfr_pkg::*;

  logic             valid_q;
  logic             phase_q;
  logic             load;
  logic             final_res;
  logic [KindW-1:0] kind_d, kind_q;
  logic [ByteW-1:0] start_d, start_q, src_d, src_q, dst_d, dst_q;
  logic [ByteW-1:0] cmd_q, d1_q, d2_q;
  logic             last_d, last_q;

  assign load  = !empty_i && (!valid_q || res_o.ready);
  assign pop_o = load && final_res;

  always_comb begin
    kind_d    = KIND_MSG;
    start_d   = head_i.start;
    src_d     = head_i.src;
    dst_d     = head_i.dst;
    last_d    = 1'b1;
    final_res = 1'b1;
    unique case (head_i.act)
      ACT_ACK: begin
        if (!phase_q) begin
          kind_d    = KIND_RESP;
          start_d   = head_i.code_resp;
          src_d     = head_i.dst;
          dst_d     = head_i.src;
          last_d    = 1'b0;
          final_res = 1'b0;
        end else begin
          start_d = head_i.code_std;
        end
      end
      ACT_CLR: begin
        kind_d  = KIND_CLR;
        start_d = head_i.code_std;
        src_d   = head_i.dst;
        dst_d   = head_i.src;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        phase_q <= !final_res;
      end else if (res_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= kind_d;
      start_q <= start_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      cmd_q   <= head_i.cmd;
      d1_q    <= head_i.data_first;
      d2_q    <= head_i.data_second;
      last_q  <= last_d;
    end
  end

  assign res_o.valid       = valid_q;
  assign res_o.kind        = kind_q;
  assign res_o.start_code  = start_q;
  assign res_o.source_addr = src_q;
  assign res_o.dest_addr   = dst_q;
  assign res_o.command     = cmd_q;
  assign res_o.data_first  = d1_q;
  assign res_o.data_second = d2_q;
  assign res_o.last        = last_q;

  a_phase_only_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (!empty_i && (head_i.act == ACT_ACK)))
    else $error("second result pending without an ack job at head");

endmodule
